[hdl/signed_int_to_decimal_ascii_core_defines.svh]
// Assertion macros shared by the decimal conversion modules.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIDA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define SIDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

[hdl/sida_pkg.sv]
// Shared types, constants and a helper function for the decimal conversion core.
// Used by sida_ctrl, sida_dp and the top level; depends on nothing.
package sida_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned WIDE_W  = 34;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic pos_zero;
    } sts_t;

    function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] k);
        logic [WIDE_W-1:0] p;
        case (k)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            4'd10:   p = 34'd10000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

[hdl/signed_int_to_decimal_ascii_core.sv]
// Converts one signed 32-bit integer per start into its decimal ASCII text, one character
// per strobe, most significant first, with a leading '-' for negative values and last
// marking the final character. An accepted word is loaded in its accepting cycle, the scan
// state then finds its leading digit position, and the sign and digit states follow with
// busy high from the scan state through the state of the last character. The single
// digit-extraction unit produces one character per cycle. Each character appears on
// character and last for exactly one cycle with strobe high; the receiver cannot stall
// it. Depends on sida_pkg, sida_ctrl and sida_dp.
module signed_int_to_decimal_ascii_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sida_pkg::VALUE_W-1:0] value,
    output logic [sida_pkg::CHAR_W-1:0]         character,
    output logic                                last,
    output logic                                strobe
);

    sida_pkg::cmd_t cmd;
    sida_pkg::sts_t sts;

    sida_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    sida_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .sts       (sts),
        .character (character),
        .last      (last),
        .strobe    (strobe)
    );

endmodule

[hdl/sida_ctrl.sv]
// Controller state machine for the decimal conversion core.
// Depends on sida_pkg and the assertion macro header.
`include "signed_int_to_decimal_ascii_core_defines.svh"

module sida_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  sida_pkg::sts_t  sts,
    output sida_pkg::cmd_t  cmd,
    output logic            busy
);

    sida_pkg::state_t state_reg;
    sida_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sida_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sida_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sida_pkg::ST_SCAN;
                end
            end
            sida_pkg::ST_SCAN:
            begin
                state_next = sts.neg ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGIT;
            end
            sida_pkg::ST_SIGN:
            begin
                state_next = sida_pkg::ST_DIGIT;
            end
            sida_pkg::ST_DIGIT:
            begin
                if (sts.pos_zero)
                begin
                    state_next = sida_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sida_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            sida_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            sida_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            sida_pkg::ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
            end
            sida_pkg::ST_DIGIT:
            begin
                cmd.emit_digit = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    `SIDA_ASSERT_SAME(a_load_only_idle, cmd.load, !busy && start)
    `SIDA_ASSERT_NEXT(a_load_then_scan, cmd.load, state_reg == sida_pkg::ST_SCAN)
    `SIDA_ASSERT_NEXT(a_sign_then_digit, cmd.emit_sign, cmd.emit_digit)

endmodule

[hdl/sida_dp.sv]
// Datapath for the decimal conversion core: magnitude, digit position and output word.
// Depends on sida_pkg and the assertion macro header.
`include "signed_int_to_decimal_ascii_core_defines.svh"

module sida_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sida_pkg::cmd_t                    cmd,
    input  logic signed [sida_pkg::VALUE_W-1:0] value,
    output sida_pkg::sts_t                    sts,
    output logic [sida_pkg::CHAR_W-1:0]       character,
    output logic                              last,
    output logic                              strobe
);

    logic [sida_pkg::VALUE_W-1:0] mag_reg;
    logic [sida_pkg::VALUE_W-1:0] mag_next;
    logic                         neg_reg;
    logic [sida_pkg::POS_W-1:0]   pos_reg;
    logic [sida_pkg::POS_W-1:0]   pos_next;
    logic [sida_pkg::CHAR_W-1:0]  character_reg;
    logic [sida_pkg::CHAR_W-1:0]  character_next;
    logic                         last_reg;
    logic                         last_next;
    logic                         strobe_reg;

    logic [sida_pkg::VALUE_W-1:0] raw;
    logic [sida_pkg::WIDE_W-1:0]  mag_wide;
    logic [sida_pkg::WIDE_W-1:0]  place;
    logic [sida_pkg::WIDE_W-1:0]  take;
    logic [sida_pkg::POS_W-1:0]   top_pos;
    logic [sida_pkg::POS_W-1:0]   digit;

    assign raw      = $unsigned(value);
    assign mag_wide = {2'b00, mag_reg};
    assign place    = sida_pkg::pow10(pos_reg);

    // The highest digit position is the number of powers of ten from 10 to 10^9 that do not exceed the value.
    always_comb
    begin
        top_pos = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (mag_wide >= sida_pkg::pow10(sida_pkg::POS_W'(k)))
            begin
                top_pos = top_pos + 1'b1;
            end
        end
    end

    // The digit at the current position is the largest multiple of its place value that fits.
    always_comb
    begin
        digit = '0;
        take  = '0;
        for (int d = 1; d <= 9; d++)
        begin
            if (mag_wide >= sida_pkg::WIDE_W'(d) * place)
            begin
                digit = sida_pkg::POS_W'(d);
                take  = sida_pkg::WIDE_W'(d) * place;
            end
        end
    end

    always_comb
    begin
        mag_next       = mag_reg;
        pos_next       = pos_reg;
        character_next = character_reg;
        last_next      = last_reg;
        if (cmd.load)
        begin
            mag_next = raw[sida_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
        end
        if (cmd.scan)
        begin
            pos_next = top_pos;
        end
        if (cmd.emit_sign)
        begin
            character_next = sida_pkg::ASCII_MINUS;
            last_next      = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            mag_next       = mag_reg - take[sida_pkg::VALUE_W-1:0];
            pos_next       = pos_reg - 1'b1;
            character_next = sida_pkg::ASCII_ZERO + {4'd0, digit};
            last_next      = (pos_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        pos_reg       <= pos_next;
        character_reg <= character_next;
        last_reg      <= last_next;
        if (cmd.load)
        begin
            neg_reg <= raw[sida_pkg::VALUE_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_sign | cmd.emit_digit;
        end
    end

    assign sts.neg      = neg_reg;
    assign sts.pos_zero = (pos_reg == '0);
    assign character    = character_reg;
    assign last         = last_reg;
    assign strobe       = strobe_reg;

    `SIDA_ASSERT_NEXT(a_final_digit_last, cmd.emit_digit && (pos_reg == '0), strobe_reg && last_reg)
    `SIDA_ASSERT_NEXT(a_sign_word, cmd.emit_sign, strobe_reg && !last_reg && (character_reg == sida_pkg::ASCII_MINUS))
    `SIDA_ASSERT_SAME(a_mag_fits_place, cmd.emit_digit, mag_wide < sida_pkg::pow10(pos_reg + 1'b1))

endmodule
